@@ hw/rtl/increasing_tuple_product_sum_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tuple product sum checkers.
// ----------------------------------------------------------------------------
`ifndef INCREASING_TUPLE_PRODUCT_SUM_MACROS_SVH
`define INCREASING_TUPLE_PRODUCT_SUM_MACROS_SVH

// Checked on every rising edge while the reset is released.
`define ITPS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ITPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/itps_pkg.sv @@
// ----------------------------------------------------------------------------
// itps_pkg
// Widths, constants, the lane item type and helper functions shared by the
// tuple product sum lanes, the output stage and the top level.
// ----------------------------------------------------------------------------
package itps_pkg;

	localparam int MAX_FACTORS   = 4;
	localparam int VALUE_BITS    = 32;
	localparam int FRAC_BITS     = 24;
	localparam int FACTOR_INPUTS = 4;
	localparam int FIELD_W       = 32;
	localparam int SUM_W         = 64;
	localparam int COUNT_W       = 3;
	localparam int COUNT_MIN     = 2;

	localparam int NUM_LANES  = (MAX_FACTORS < FACTOR_INPUTS) ? MAX_FACTORS : FACTOR_INPUTS;
	localparam int FW         = VALUE_BITS;
	localparam int FIDX_W     = $clog2(FACTOR_INPUTS);
	localparam int IN_DATA_W  = 2 * FACTOR_INPUTS * FIELD_W;
	localparam int OUT_DATA_W = 2 * SUM_W;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [SUM_W-1:0] ONE_VAL = SUM_W'(1) << FRAC_BITS;

	// One item as it travels down the lane chain.
	typedef struct packed {
		logic                                valid;
		logic                                last;
		logic [COUNT_W-1:0]                  n;
		logic [FACTOR_INPUTS-1:0][FW-1:0]    fre;
		logic [FACTOR_INPUTS-1:0][FW-1:0]    fim;
		logic [SUM_W-1:0]                    res_re;
		logic [SUM_W-1:0]                    res_im;
		logic                                ovf;
	} item_t;

	// Keeps the low VALUE_BITS bits of a field; the lane reads them as signed.
	function automatic logic [FW-1:0] take_value(input logic [FIELD_W-1:0] x);
		logic [FW+FIELD_W-1:0] w;
		w = {{FW{1'b0}}, x};
		return w[FW-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
		if (c < COUNT_W'(COUNT_MIN)) begin
			return COUNT_W'(COUNT_MIN);
		end
		if (c > COUNT_W'(NUM_LANES)) begin
			return COUNT_W'(NUM_LANES);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/itps_lane.sv @@
// ----------------------------------------------------------------------------
// itps_lane
// One order of the recurrence: multiplies the previous order's partial sum by
// this lane's factor, rounds and saturates, and accumulates into its own sum.
// ----------------------------------------------------------------------------
module itps_lane import itps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [COUNT_W-1:0] lane_no,
	input  item_t              in_item,
	input  logic [SUM_W-1:0]   prev_re,
	input  logic [SUM_W-1:0]   prev_im,
	output item_t              out_item,
	output logic [SUM_W-1:0]   next_re,
	output logic [SUM_W-1:0]   next_im
);

	localparam int HALF_W = SUM_W / 2;
	localparam int PH_W   = HALF_W + FW;
	localparam int PL_W   = HALF_W + 1 + FW;
	localparam int HI_W   = PH_W + 1;
	localparam int LO_W   = PL_W + 1;
	localparam int W      = SUM_W + FW + 2;
	localparam logic signed [W-1:0] HALF_LSB = W'(1) <<< (FRAC_BITS - 1);

	// Rounded value to SUM_W bits, with the saturation flag on top.
	function automatic logic [SUM_W:0] fit(input logic signed [W-1:0] s);
		logic [W-SUM_W:0] hi;
		hi = s[W-1:SUM_W-1];
		if ((&hi) || (~|hi)) begin
			return {1'b0, s[SUM_W-1:0]};
		end
		return {1'b1, s[W-1] ? SUM_MIN : SUM_MAX};
	endfunction

	function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] a,
	                                           input logic [SUM_W-1:0] b);
		logic [SUM_W-1:0] r;
		r = a + b;
		if ((a[SUM_W-1] == b[SUM_W-1]) && (r[SUM_W-1] != a[SUM_W-1])) begin
			return {1'b1, a[SUM_W-1] ? SUM_MIN : SUM_MAX};
		end
		return {1'b0, r};
	endfunction

	item_t item_s1, item_s2, item_s3, item_s4, out_next;

	logic [FIDX_W-1:0]        fidx;
	logic signed [FW-1:0]     fc, fd;
	logic signed [HALF_W-1:0] ah, bh;
	logic signed [HALF_W:0]   al, bl;

	logic signed [PH_W-1:0] ahc_s1, bhd_s1, ahd_s1, bhc_s1;
	logic signed [PL_W-1:0] alc_s1, bld_s1, ald_s1, blc_s1;
	logic signed [HI_W-1:0] hi_re_s2, hi_im_s2;
	logic signed [LO_W-1:0] lo_re_s2, lo_im_s2;
	logic signed [W-1:0]    full_re, full_im;
	logic [SUM_W:0]         fit_re, fit_im;
	logic [SUM_W-1:0]       val_re_s3, val_im_s3;
	logic                   sat_s3;

	logic [SUM_W-1:0] acc_re_q, acc_im_q, old_re_q, old_im_q;
	logic             sat_q;
	logic [SUM_W:0]   add_re, add_im;
	logic [SUM_W-1:0] new_re, new_im;
	logic             active, cur_sat;

	assign fidx = FIDX_W'(lane_no - COUNT_W'(1));
	assign fc   = signed'(in_item.fre[fidx]);
	assign fd   = signed'(in_item.fim[fidx]);

	// Split the 64 bit sums into a signed upper and an unsigned lower half.
	assign ah = signed'(prev_re[SUM_W-1:HALF_W]);
	assign bh = signed'(prev_im[SUM_W-1:HALF_W]);
	assign al = signed'({1'b0, prev_re[HALF_W-1:0]});
	assign bl = signed'({1'b0, prev_im[HALF_W-1:0]});

	assign full_re = (W'(hi_re_s2) <<< HALF_W) + W'(lo_re_s2) + HALF_LSB;
	assign full_im = (W'(hi_im_s2) <<< HALF_W) + W'(lo_im_s2) + HALF_LSB;
	assign fit_re  = fit(full_re >>> FRAC_BITS);
	assign fit_im  = fit(full_im >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (adv) begin
			ahc_s1 <= ah * fc;
			bhd_s1 <= bh * fd;
			ahd_s1 <= ah * fd;
			bhc_s1 <= bh * fc;
			alc_s1 <= al * fc;
			bld_s1 <= bl * fd;
			ald_s1 <= al * fd;
			blc_s1 <= bl * fc;

			hi_re_s2 <= HI_W'(ahc_s1) - HI_W'(bhd_s1);
			hi_im_s2 <= HI_W'(ahd_s1) + HI_W'(bhc_s1);
			lo_re_s2 <= LO_W'(alc_s1) - LO_W'(bld_s1);
			lo_im_s2 <= LO_W'(ald_s1) + LO_W'(blc_s1);

			val_re_s3 <= fit_re[SUM_W-1:0];
			val_im_s3 <= fit_im[SUM_W-1:0];
			sat_s3    <= fit_re[SUM_W] | fit_im[SUM_W];
		end
	end

	assign active  = item_s3.valid && (lane_no <= item_s3.n);
	assign add_re  = sat_add(acc_re_q, val_re_s3);
	assign add_im  = sat_add(acc_im_q, val_im_s3);
	assign new_re  = active ? add_re[SUM_W-1:0] : acc_re_q;
	assign new_im  = active ? add_im[SUM_W-1:0] : acc_im_q;
	assign cur_sat = active && (sat_s3 || add_re[SUM_W] || add_im[SUM_W]);

	// On the last copy the lane of order n hands over its sum, and every lane
	// folds its saturation history into the item.
	always_comb begin
		out_next = item_s3;
		if (item_s3.valid && item_s3.last) begin
			if (lane_no == item_s3.n) begin
				out_next.res_re = new_re;
				out_next.res_im = new_im;
			end
			out_next.ovf = item_s3.ovf | sat_q | cur_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1  <= '0;
			item_s2  <= '0;
			item_s3  <= '0;
			item_s4  <= '0;
			acc_re_q <= '0;
			acc_im_q <= '0;
			old_re_q <= '0;
			old_im_q <= '0;
			sat_q    <= 1'b0;
		end else if (adv) begin
			item_s1 <= in_item;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= out_next;
			if (item_s3.valid) begin
				// The next lane sees this item paired with the sum from before it.
				old_re_q <= acc_re_q;
				old_im_q <= acc_im_q;
				if (item_s3.last) begin
					acc_re_q <= '0;
					acc_im_q <= '0;
					sat_q    <= 1'b0;
				end else begin
					acc_re_q <= new_re;
					acc_im_q <= new_im;
					sat_q    <= sat_q | cur_sat;
				end
			end
		end
	end

	assign out_item = item_s4;
	assign next_re  = old_re_q;
	assign next_im  = old_im_q;

endmodule

@@ hw/rtl/itps_merge.sv @@
// ----------------------------------------------------------------------------
// itps_merge
// Collects the finished sum and overflow flag at the end of the lane chain
// into the output register and derives the pipeline advance.
// ----------------------------------------------------------------------------
module itps_merge import itps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  item_t                 last_item,
	input  logic                  m_axis_tready,
	output logic                  adv,
	output logic                  m_axis_tvalid,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // sum_re, sum_im
	output logic [0:0]            m_axis_tuser   // overflowed
);

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_ovf_q;
	logic                  result;

	assign result = last_item.valid && last_item.last;

	// Only an item with a result has to wait for the output register.
	assign adv = !(out_valid_q && !m_axis_tready && result);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && result) begin
			out_data_q <= {last_item.res_im, last_item.res_re};
			out_ovf_q  <= last_item.ovf;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_ovf_q;

endmodule

@@ hw/rtl/increasing_tuple_product_sum.sv @@
// ----------------------------------------------------------------------------
// increasing_tuple_product_sum
// Sum over strictly increasing copy tuples of the product of complex factors.
// ----------------------------------------------------------------------------
// Each input item is one noise copy with four complex Q7.24 factors on
// s_axis_tdata; s_axis_tlast marks the final copy of a configuration. On that
// copy one result leaves on m_axis: the Q39.24 sum on m_axis_tdata and the
// saturation flag on m_axis_tuser. Other copies give no result.
// cfg_we/cfg_wdata set the tuple order n (clamped to 2..4, reset 2); write it
// only while no item is in flight.
// One lane per order runs a four stage multiply, round and accumulate
// pipeline; each lane sees an item when it leaves the lane before it, so
// the recurrence closes through one accumulator register per lane.
// Throughput is one item per cycle while s_axis_tready is high. A result
// passes four lanes of four stages, then the output register.
// Reset clears all partial sums, the flag and the pipeline at once.
// When the receiver stalls, the result stays in the output register and the
// block keeps taking items until a second result reaches the chain end; then
// s_axis_tready drops until the first one is taken.
// ----------------------------------------------------------------------------
module increasing_tuple_product_sum import itps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COUNT_W-1:0]    cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// f0_re, f0_im, f1_re, f1_im, f2_re, f2_im, f3_re, f3_im
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tlast,   // last_copy
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // sum_re, sum_im
	output logic [0:0]            m_axis_tuser    // overflowed
);

	logic [COUNT_W-1:0] count_q;
	logic               adv;
	item_t              in_item;
	item_t              chain [NUM_LANES+1];
	logic [SUM_W-1:0]   link_re [NUM_LANES];
	logic [SUM_W-1:0]   link_im [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_comb begin
		in_item       = '0;
		in_item.valid = s_axis_tvalid;
		in_item.last  = s_axis_tlast;
		in_item.n     = clamp_count(count_q);
		for (int j = 0; j < FACTOR_INPUTS; j++) begin
			in_item.fre[j] = take_value(s_axis_tdata[2*j*FIELD_W +: FIELD_W]);
			in_item.fim[j] = take_value(s_axis_tdata[(2*j+1)*FIELD_W +: FIELD_W]);
		end
	end

	assign chain[0]   = in_item;
	assign link_re[0] = ONE_VAL;
	assign link_im[0] = '0;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		if (i < NUM_LANES - 1) begin : g_mid
			itps_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.lane_no  (COUNT_W'(i + 1)),
				.in_item  (chain[i]),
				.prev_re  (link_re[i]),
				.prev_im  (link_im[i]),
				.out_item (chain[i+1]),
				.next_re  (link_re[i+1]),
				.next_im  (link_im[i+1])
			);
		end else begin : g_end
			itps_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.lane_no  (COUNT_W'(i + 1)),
				.in_item  (chain[i]),
				.prev_re  (link_re[i]),
				.prev_im  (link_im[i]),
				.out_item (chain[i+1]),
				.next_re  (),
				.next_im  ()
			);
		end
	end

	itps_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.last_item     (chain[NUM_LANES]),
		.m_axis_tready (m_axis_tready),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	assign s_axis_tready = adv;

endmodule

@@ hw/rtl/itps_checker.sv @@
// ----------------------------------------------------------------------------
// itps_checker
// Port level checks of the tuple product sum block, bound to the top level.
// ----------------------------------------------------------------------------
`include "increasing_tuple_product_sum_macros.svh"

module itps_checker import itps_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [0:0]            m_axis_tuser
);

	// A waiting result keeps its value until it is taken.
	`ITPS_ASSERT(a_out_hold, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "result changed while stalled")

	// The output register is known to be empty from the edge after reset is seen.
	`ITPS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !m_axis_tvalid, "result shown during reset")

	// With the output register free or draining, the input side never waits.
	`ITPS_ASSERT(a_ready_free, clk, arst_n, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input stalled with free output")

	// A new result is loaded only on a cycle in which the chain advanced.
	`ITPS_ASSERT(a_load_adv, clk, arst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tready), "result loaded while chain held")

endmodule

bind increasing_tuple_product_sum itps_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/increasing_tuple_product_sum_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// increasing_tuple_product_sum_test
// Self-checking bench for the increasing tuple product sum block.
// ----------------------------------------------------------------------------
// Streams noise copies grouped into configurations and predicts every sum
// with a bit-exact fixed point recurrence kept in a scoreboard class. A short
// directed part covers unit and extreme factors, single copy configurations,
// clamped factor counts and a count change inside a configuration. Random
// phases follow, each under a new factor count, with bursty input, a receiver
// that stalls in changing patterns, and long runs of near full scale factors
// that drive the partial sums into saturation.
// ----------------------------------------------------------------------------
module increasing_tuple_product_sum_test;
	import itps_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int TARGET_COPIES = 1880;

	localparam logic [FIELD_W-1:0] FIX_ONE = FIELD_W'(1) << FRAC_BITS;
	localparam logic [FIELD_W-1:0] FIX_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic [FIELD_W-1:0] FIX_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	typedef enum {
		SCALE_ZERO, SCALE_ONE, SCALE_RAIL, SCALE_FLOOR,
		SCALE_UNIT, SCALE_WIDE, SCALE_FULL, SCALE_EXTREME
	} scale_t;

	typedef enum {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_t;

	// One noise copy: four complex factors and the last copy mark.
	typedef struct packed {
		logic [FACTOR_INPUTS-1:0][FIELD_W-1:0] fre;
		logic [FACTOR_INPUTS-1:0][FIELD_W-1:0] fim;
		logic                                  last;
	} copy_t;

	typedef struct {
		logic signed [SUM_W-1:0] re;
		logic signed [SUM_W-1:0] im;
		logic                    ovf;
	} sum_t;

	class sum_tracker;
		logic [COUNT_W-1:0]      factor_count;
		logic signed [SUM_W-1:0] acc_re [MAX_FACTORS];
		logic signed [SUM_W-1:0] acc_im [MAX_FACTORS];
		bit                      sat_seen;
		sum_t                    pending_sums [$];
		int                      errors;
		int                      sums_checked;
		int                      saturated_sums;

		function new();
			factor_count = COUNT_RESET;
			errors = 0;
			sums_checked = 0;
			saturated_sums = 0;
			clear_sums();
		endfunction

		function void clear_sums();
			for (int k = 0; k < MAX_FACTORS; k++) begin
				acc_re[k] = '0;
				acc_im[k] = '0;
			end
			sat_seen = 1'b0;
		endfunction

		// Drops the fraction bits with round half up, then clips to 64 bits.
		function logic signed [SUM_W-1:0] round_product(input logic signed [127:0] p,
				inout bit sat);
			logic signed [127:0] r;
			r = (p + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (r[127:SUM_W-1] != {(129-SUM_W){r[SUM_W-1]}}) begin
				sat = 1'b1;
				return r[127] ? SUM_MIN : SUM_MAX;
			end
			return r[SUM_W-1:0];
		endfunction

		function logic signed [SUM_W-1:0] saturating_add(input logic signed [SUM_W-1:0] a,
				input logic signed [SUM_W-1:0] b, inout bit sat);
			logic signed [SUM_W-1:0] s;
			s = a + b;
			if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
				sat = 1'b1;
				return a[SUM_W-1] ? SUM_MIN : SUM_MAX;
			end
			return s;
		endfunction

		// Advances the partial sums by one copy, from the highest order down,
		// so each order reads the value the order below held before this copy.
		function void absorb_copy(input copy_t c);
			logic signed [127:0]     pr, pi, fr, fi;
			logic signed [SUM_W-1:0] t_re, t_im;
			int                      n;
			bit                      sat;
			sum_t                    s;
			n = (factor_count < COUNT_MIN) ? COUNT_MIN :
				(factor_count > NUM_LANES) ? NUM_LANES : int'(factor_count);
			sat = 1'b0;
			for (int k = n; k >= 1; k--) begin
				if (k == 1) begin
					pr = ONE_VAL;
					pi = '0;
				end else begin
					pr = acc_re[k-2];
					pi = acc_im[k-2];
				end
				fr = $signed(c.fre[k-1][VALUE_BITS-1:0]);
				fi = $signed(c.fim[k-1][VALUE_BITS-1:0]);
				t_re = round_product(pr * fr - pi * fi, sat);
				t_im = round_product(pr * fi + pi * fr, sat);
				acc_re[k-1] = saturating_add(acc_re[k-1], t_re, sat);
				acc_im[k-1] = saturating_add(acc_im[k-1], t_im, sat);
			end
			sat_seen |= sat;
			if (c.last) begin
				s.re = acc_re[n-1];
				s.im = acc_im[n-1];
				s.ovf = sat_seen;
				pending_sums.push_back(s);
				clear_sums();
			end
		endfunction

		function void check_sum(input logic signed [SUM_W-1:0] re,
				input logic signed [SUM_W-1:0] im, input logic ovf);
			sum_t want;
			if (pending_sums.size() == 0) begin
				$error("unexpected sum: sum_re %0d, sum_im %0d, overflowed %0b", re, im, ovf);
				errors++;
				return;
			end
			want = pending_sums.pop_front();
			if (re !== want.re) begin
				$error("sum_re: expected %0d, got %0d", want.re, re);
				errors++;
			end
			if (im !== want.im) begin
				$error("sum_im: expected %0d, got %0d", want.im, im);
				errors++;
			end
			if (ovf !== want.ovf) begin
				$error("overflowed: expected %0b, got %0b", want.ovf, ovf);
				errors++;
			end
			sums_checked++;
			if (want.ovf) begin
				saturated_sums++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [COUNT_W-1:0]    cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	sum_tracker sb = new();

	int       burst_left = 0;
	int       copies_sent = 0;
	int       configs_sent = 0;
	int       count_writes = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_hold = 0;

	increasing_tuple_product_sum u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Result side: check on the handshake, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_sum(m_axis_tdata[SUM_W-1:0], m_axis_tdata[2*SUM_W-1:SUM_W],
				m_axis_tuser[0]);
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(64, 512);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				m_axis_tready <= 1'b1;
			end
			RX_COIN: begin
				m_axis_tready <= 1'($urandom_range(0, 1));
			end
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
					rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
				end
			end
		endcase
	end

	function automatic logic [FIELD_W-1:0] factor_value(input scale_t sc);
		case (sc)
			SCALE_ZERO:  return '0;
			SCALE_ONE:   return FIX_ONE;
			SCALE_RAIL:  return FIX_MAX - FIELD_W'($urandom_range(0, 255));
			SCALE_FLOOR: return FIX_MIN + FIELD_W'($urandom_range(0, 255));
			SCALE_UNIT:  return FIELD_W'($urandom_range(0, 2 * FIX_ONE)) - FIX_ONE;
			SCALE_WIDE:  return FIELD_W'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
			SCALE_FULL:  return FIELD_W'($urandom);
			default: begin
				case ($urandom_range(0, 5))
					0:       return FIX_MAX;
					1:       return FIX_MIN;
					2:       return '0;
					3:       return FIX_ONE;
					4:       return -FIX_ONE;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	task automatic push_copy(input copy_t c);
		logic [IN_DATA_W-1:0] d;
		int                   gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		for (int j = 0; j < FACTOR_INPUTS; j++) begin
			d[2*FIELD_W*j +: FIELD_W] = c.fre[j];
			d[2*FIELD_W*j+FIELD_W +: FIELD_W] = c.fim[j];
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= c.last;
		do @(posedge clk); while (!s_axis_tready);
		sb.absorb_copy(c);
		copies_sent++;
		if (c.last) begin
			configs_sent++;
		end
	endtask

	// Holds the input until every pending sum is out and the lanes are empty.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.factor_count = v;
		count_writes++;
	endtask

	task automatic run_config(input int copies, input scale_t sc, input bit close);
		copy_t c;
		for (int i = 0; i < copies; i++) begin
			for (int j = 0; j < FACTOR_INPUTS; j++) begin
				c.fre[j] = factor_value(sc);
				c.fim[j] = factor_value(sc);
			end
			c.last = close && (i == copies - 1);
			push_copy(c);
		end
	endtask

	initial begin
		int     r;
		scale_t sc;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_config(2, SCALE_ONE, 1'b1);
		// A lone copy leaves no increasing tuple, so the sum is zero.
		run_config(1, SCALE_FULL, 1'b1);
		run_config(3, SCALE_EXTREME, 1'b1);
		run_config(2, SCALE_RAIL, 1'b1);
		run_config(2, SCALE_FLOOR, 1'b1);
		write_count(3'd0);
		run_config(2, SCALE_WIDE, 1'b1);
		write_count(3'd7);
		run_config(4, SCALE_EXTREME, 1'b1);
		// The count goes up while a configuration is open; the third order
		// keeps what it gathered under the old count.
		write_count(3'd3);
		run_config(2, SCALE_UNIT, 1'b0);
		write_count(3'd4);
		run_config(3, SCALE_UNIT, 1'b1);
		write_count(3'd1);
		run_config(2, SCALE_ZERO, 1'b1);

		while (copies_sent < TARGET_COPIES) begin
			write_count($urandom_range(0, 1) ? COUNT_W'($urandom_range(0, 7)) :
				COUNT_W'($urandom_range(2, 4)));
			repeat ($urandom_range(5, 30)) begin
				r = $urandom_range(0, 19);
				if (r == 0) begin
					// Long near full scale runs push the fourth order, when in use, into saturation.
					sc = $urandom_range(0, 1) ? SCALE_RAIL : SCALE_FLOOR;
					run_config($urandom_range(17, 28), sc, 1'b1);
				end else if (r < 4) begin
					sc = $urandom_range(0, 1) ? SCALE_UNIT : SCALE_WIDE;
					run_config($urandom_range(9, 16), sc, $urandom_range(0, 19) != 0);
				end else begin
					sc = scale_t'($urandom_range(SCALE_UNIT, SCALE_EXTREME));
					run_config($urandom_range(1, 8), sc, $urandom_range(0, 19) != 0);
				end
			end
		end

		wait_idle();
		$display("Sent %0d copies closing %0d configurations, with %0d factor count writes.",
			copies_sent, configs_sent, count_writes);
		$display("Checked %0d sums, %0d of them flagged as saturated.",
			sb.sums_checked, sb.saturated_sums);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Run timed out.");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
